[design/gtdi_pkg.sv]
// Shared widths, constants, register codes and types of the geodetic tile depth and index block.
`default_nettype none
package gtdi_pkg;

	// Parameter defaults.
	localparam int GTDI_MAX_THRESHOLDS = 6;
	localparam int GTDI_MAX_DEPTH      = 24;

	// Field and register widths.
	localparam int NUM_THR   = 6;
	localparam int BOX_W     = 31;
	localparam int EXT_W     = 32;
	localparam int LON_W     = 32;
	localparam int LAT_W     = 30;
	localparam int LATR_W    = 31;
	localparam int THR_W     = 31;
	localparam int DEPTH_W   = 5;
	localparam int CNT_W     = 3;
	localparam int X_W       = 25;
	localparam int Y_W       = 24;
	localparam int REG_IDX_W = 3;
	localparam int STEP_W    = 30;

	// Angles in units of 2^-22 degree.
	localparam logic [LON_W-1:0]  HALF_TURN    = 32'd754974720;
	localparam logic [LON_W-1:0]  FULL_TURN    = 32'd1509949440;
	localparam logic [LATR_W-1:0] QUARTER_TURN = 31'd377487360;

	// Configuration register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_INITIAL_DEPTH   = 3'd0,
		REG_THRESHOLD_COUNT = 3'd1,
		REG_THRESHOLD_0     = 3'd2,
		REG_THRESHOLD_1     = 3'd3,
		REG_THRESHOLD_2     = 3'd4,
		REG_THRESHOLD_3     = 3'd5,
		REG_THRESHOLD_4     = 3'd6,
		REG_THRESHOLD_5     = 3'd7
	} reg_idx_t;

	typedef logic [NUM_THR-1:0][THR_W-1:0] thr_vec_t;

	// Configuration as seen by the depth selection.
	typedef struct packed {
		logic [DEPTH_W-1:0] initial_depth;
		logic [CNT_W-1:0]   threshold_count;
		thr_vec_t           thresholds;
	} cfg_t;

	// Payload that travels through the bisection stages.
	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [LON_W-1:0]   lon_r;
		logic [LATR_W-1:0]  lat_r;
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
	} bis_t;

endpackage
`default_nettype wire

[design/gtdi_depth.sv]
// Front pipeline: box extents, largest extent, threshold search, depth and position offsets.
`default_nettype none
module gtdi_depth #(
	parameter int MAX_THRESHOLDS = gtdi_pkg::GTDI_MAX_THRESHOLDS,
	parameter int MAX_DEPTH      = gtdi_pkg::GTDI_MAX_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic [gtdi_pkg::BOX_W-1:0]    min_x,
	input  wire logic [gtdi_pkg::BOX_W-1:0]    min_y,
	input  wire logic [gtdi_pkg::BOX_W-1:0]    min_z,
	input  wire logic [gtdi_pkg::BOX_W-1:0]    max_x,
	input  wire logic [gtdi_pkg::BOX_W-1:0]    max_y,
	input  wire logic [gtdi_pkg::BOX_W-1:0]    max_z,
	input  wire logic [gtdi_pkg::LON_W-1:0]    lon_fixed,
	input  wire logic [gtdi_pkg::LAT_W-1:0]    lat_fixed,
	input  wire gtdi_pkg::cfg_t                cfg,
	output logic                               out_valid,
	output gtdi_pkg::bis_t                     out_bis
);

	localparam int EW = gtdi_pkg::EXT_W;
	localparam int LW = gtdi_pkg::LON_W;
	localparam int RW = gtdi_pkg::LATR_W;
	localparam int CW = gtdi_pkg::CNT_W;
	localparam int DW = gtdi_pkg::DEPTH_W;

	logic          valid_s1, valid_s2, valid_s3, valid_s4;
	logic [EW-1:0] ext_x_s1, ext_y_s1, ext_z_s1;
	logic [LW-1:0] lon_s1;
	logic [RW-1:0] lat_r_s1, lat_r_s2, lat_r_s3;
	logic [EW-1:0] big_s2;
	logic [LW-1:0] lon_r_s2, lon_r_s3;
	logic          east_s2, east_s3;
	logic [MAX_THRESHOLDS-1:0] hit_s3;
	gtdi_pkg::bis_t bis_s4;

	logic [EW-1:0] max_xy;
	logic [CW-1:0] count_sat;
	logic [CW-1:0] first_idx;
	logic [DW:0]   depth_raw;
	logic [DW-1:0] depth_clamped;
	logic [MAX_THRESHOLDS-1:0] hit_d;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: signed extents, longitude wrap and latitude offset from the south pole.
	always_ff @(posedge clk) begin
		ext_x_s1 <= {max_x[gtdi_pkg::BOX_W-1], max_x} - {min_x[gtdi_pkg::BOX_W-1], min_x};
		ext_y_s1 <= {max_y[gtdi_pkg::BOX_W-1], max_y} - {min_y[gtdi_pkg::BOX_W-1], min_y};
		ext_z_s1 <= {max_z[gtdi_pkg::BOX_W-1], max_z} - {min_z[gtdi_pkg::BOX_W-1], min_z};
		if ($signed(lon_fixed) >= $signed(gtdi_pkg::HALF_TURN)) begin
			lon_s1 <= lon_fixed - gtdi_pkg::FULL_TURN;
		end else begin
			lon_s1 <= lon_fixed;
		end
		lat_r_s1 <= {lat_fixed[gtdi_pkg::LAT_W-1], lat_fixed} + gtdi_pkg::QUARTER_TURN;
	end

	// Stage 2: largest extent and offset into the chosen half.
	always_comb begin
		max_xy = ($signed(ext_x_s1) > $signed(ext_y_s1)) ? ext_x_s1 : ext_y_s1;
	end

	always_ff @(posedge clk) begin
		big_s2   <= ($signed(max_xy) > $signed(ext_z_s1)) ? max_xy : ext_z_s1;
		east_s2  <= ~lon_s1[LW-1];
		lon_r_s2 <= lon_s1[LW-1] ? (lon_s1 + gtdi_pkg::HALF_TURN) : lon_s1;
		lat_r_s2 <= lat_r_s1;
	end

	// Stage 3: compare the largest extent against every active threshold.
	always_comb begin
		count_sat = (cfg.threshold_count > CW'(MAX_THRESHOLDS)) ? CW'(MAX_THRESHOLDS)
			: cfg.threshold_count;
		for (int k = 0; k < MAX_THRESHOLDS; k++) begin
			hit_d[k] = (CW'(k) < count_sat)
				&& ($signed(big_s2) >= $signed({1'b0, cfg.thresholds[k]}));
		end
	end

	always_ff @(posedge clk) begin
		hit_s3   <= hit_d;
		east_s3  <= east_s2;
		lon_r_s3 <= lon_r_s2;
		lat_r_s3 <= lat_r_s2;
	end

	// Stage 4: first hit wins; no hit means the active count. Then add and clamp.
	always_comb begin
		first_idx = (cfg.threshold_count > CW'(MAX_THRESHOLDS)) ? CW'(MAX_THRESHOLDS)
			: cfg.threshold_count;
		for (int k = MAX_THRESHOLDS - 1; k >= 0; k--) begin
			if (hit_s3[k]) begin
				first_idx = CW'(k);
			end
		end
		depth_raw = {1'b0, cfg.initial_depth} + {{(DW + 1 - CW){1'b0}}, first_idx};
		depth_clamped = (depth_raw > (DW + 1)'(MAX_DEPTH)) ? DW'(MAX_DEPTH) : depth_raw[DW-1:0];
	end

	always_ff @(posedge clk) begin
		bis_s4.depth <= depth_clamped;
		bis_s4.lon_r <= lon_r_s3;
		bis_s4.lat_r <= lat_r_s3;
		bis_s4.x     <= gtdi_pkg::X_W'(east_s3);
		bis_s4.y     <= '0;
	end

	assign out_valid = valid_s4;
	assign out_bis   = bis_s4;

endmodule
`default_nettype wire

[design/gtdi_bisect_stage.sv]
// One bisection step of longitude and latitude, one register stage.
`default_nettype none
module gtdi_bisect_stage #(
	parameter int STEP = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire gtdi_pkg::bis_t in_bis,
	output logic                out_valid,
	output gtdi_pkg::bis_t      out_bis
);

	localparam int LW = gtdi_pkg::LON_W;
	localparam int RW = gtdi_pkg::LATR_W;
	localparam int SW = gtdi_pkg::STEP_W;
	localparam logic [SW-1:0] HALF_W = SW'(gtdi_pkg::HALF_TURN >> (STEP + 1));

	logic           valid_s1;
	gtdi_pkg::bis_t bis_s1;
	gtdi_pkg::bis_t nxt;
	logic           active;
	logic [LW:0]    lon_d;
	logic [RW:0]    lat_d;
	logic           lon_ge, lat_ge;

	// Offsets at or above the half width move to the upper half and emit a bit.
	always_comb begin
		active = in_bis.depth > gtdi_pkg::DEPTH_W'(STEP);
		lon_d  = {in_bis.lon_r[LW-1], in_bis.lon_r} - {{(LW + 1 - SW){1'b0}}, HALF_W};
		lat_d  = {in_bis.lat_r[RW-1], in_bis.lat_r} - {{(RW + 1 - SW){1'b0}}, HALF_W};
		lon_ge = ~lon_d[LW];
		lat_ge = ~lat_d[RW];
		nxt    = in_bis;
		if (active) begin
			nxt.x = {in_bis.x[gtdi_pkg::X_W-2:0], lon_ge};
			nxt.y = {in_bis.y[gtdi_pkg::Y_W-2:0], ~lat_ge};
			if (lon_ge) begin
				nxt.lon_r = lon_d[LW-1:0];
			end
			if (lat_ge) begin
				nxt.lat_r = lat_d[RW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		bis_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_bis   = bis_s1;

endmodule
`default_nettype wire

[design/geodetic_tile_depth_and_index.sv]
// Top level of the geodetic tile depth and index pipeline with its configuration registers.
//
//  Channel   Handshake           Payload
//  --------  ------------------  ---------------------------------------------------
//  input     start / busy        min_x min_y min_z max_x max_y max_z lon_fixed lat_fixed
//  result    done                tile_depth x_index y_index
//  config    wr_en               wr_index wr_data
//
// One beat enters in every cycle; busy stays low. Each result appears on done
// after passing four front stages for extents, maximum, threshold compare and
// depth, then one stage per bisection step. Reset clears the valid bits and loads
// the register reset values. The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module geodetic_tile_depth_and_index #(
	parameter int MAX_THRESHOLDS = gtdi_pkg::GTDI_MAX_THRESHOLDS,
	parameter int MAX_DEPTH      = gtdi_pkg::GTDI_MAX_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [gtdi_pkg::BOX_W-1:0]       min_x,
	input  wire logic [gtdi_pkg::BOX_W-1:0]       min_y,
	input  wire logic [gtdi_pkg::BOX_W-1:0]       min_z,
	input  wire logic [gtdi_pkg::BOX_W-1:0]       max_x,
	input  wire logic [gtdi_pkg::BOX_W-1:0]       max_y,
	input  wire logic [gtdi_pkg::BOX_W-1:0]       max_z,
	input  wire logic [gtdi_pkg::LON_W-1:0]       lon_fixed,
	input  wire logic [gtdi_pkg::LAT_W-1:0]       lat_fixed,
	output logic                                  done,
	output logic [gtdi_pkg::DEPTH_W-1:0]          tile_depth,
	output logic [gtdi_pkg::X_W-1:0]              x_index,
	output logic [gtdi_pkg::Y_W-1:0]              y_index,
	input  wire logic                             wr_en,
	input  wire logic [gtdi_pkg::REG_IDX_W-1:0]   wr_index,
	input  wire logic [gtdi_pkg::THR_W-1:0]       wr_data
);

	localparam int LATENCY = 4 + MAX_DEPTH;

	logic [gtdi_pkg::DEPTH_W-1:0] initial_depth_q;
	logic [gtdi_pkg::CNT_W-1:0]   threshold_count_q;
	gtdi_pkg::thr_vec_t           thresholds_q;
	gtdi_pkg::cfg_t               cfg;

	logic                 vchain [MAX_DEPTH + 1];
	gtdi_pkg::bis_t       bchain [MAX_DEPTH + 1];

	// The pipeline takes a beat in every cycle.
	assign busy = 1'b0;

	// Configuration registers; unknown indexes cannot occur in a 3-bit index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_depth_q   <= '0;
			threshold_count_q <= gtdi_pkg::CNT_W'(6);
			thresholds_q      <= '0;
		end else if (wr_en) begin
			case (wr_index)
				gtdi_pkg::REG_INITIAL_DEPTH:   initial_depth_q   <= wr_data[gtdi_pkg::DEPTH_W-1:0];
				gtdi_pkg::REG_THRESHOLD_COUNT: threshold_count_q <= wr_data[gtdi_pkg::CNT_W-1:0];
				gtdi_pkg::REG_THRESHOLD_0:     thresholds_q[0]   <= wr_data;
				gtdi_pkg::REG_THRESHOLD_1:     thresholds_q[1]   <= wr_data;
				gtdi_pkg::REG_THRESHOLD_2:     thresholds_q[2]   <= wr_data;
				gtdi_pkg::REG_THRESHOLD_3:     thresholds_q[3]   <= wr_data;
				gtdi_pkg::REG_THRESHOLD_4:     thresholds_q[4]   <= wr_data;
				gtdi_pkg::REG_THRESHOLD_5:     thresholds_q[5]   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg.initial_depth   = initial_depth_q;
	assign cfg.threshold_count = threshold_count_q;
	assign cfg.thresholds      = thresholds_q;

	// Front stages: depth selection and starting offsets.
	gtdi_depth #(
		.MAX_THRESHOLDS(MAX_THRESHOLDS),
		.MAX_DEPTH(MAX_DEPTH)
	) u_depth (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(start & ~busy),
		.min_x(min_x),
		.min_y(min_y),
		.min_z(min_z),
		.max_x(max_x),
		.max_y(max_y),
		.max_z(max_z),
		.lon_fixed(lon_fixed),
		.lat_fixed(lat_fixed),
		.cfg(cfg),
		.out_valid(vchain[0]),
		.out_bis(bchain[0])
	);

	// One stage for every possible bisection step.
	for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_step
		gtdi_bisect_stage #(
			.STEP(g)
		) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(vchain[g]),
			.in_bis(bchain[g]),
			.out_valid(vchain[g + 1]),
			.out_bis(bchain[g + 1])
		);
	end

	// The last stage register drives the result ports.
	assign done       = vchain[MAX_DEPTH];
	assign tile_depth = bchain[MAX_DEPTH].depth;
	assign x_index    = bchain[MAX_DEPTH].x;
	assign y_index    = bchain[MAX_DEPTH].y;

	// Every accepted beat comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after pipeline latency");

	// Depth never exceeds the clamp.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tile_depth <= gtdi_pkg::DEPTH_W'(MAX_DEPTH)))
		else $error("tile depth above clamp");

	// Indexes hold no bits above the chosen depth, besides the east flag of x.
	a_index_width: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (((x_index >> tile_depth) <= gtdi_pkg::X_W'(1))
			&& ((y_index >> tile_depth) == '0)))
		else $error("index wider than tile depth");

	// No result without an accepted beat the latency before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(arst_n, LATENCY)) |-> $past(start && !busy, LATENCY))
		else $error("result without a matching input beat");

endmodule
`default_nettype wire
